@@ design/hc3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_pkg
// Shared types and constants of the 3x3 mod-26 hill cipher block.
// ----------------------------------------------------------------------------
package hc3_pkg;

  localparam int DEF_MAX_LETTERS = 48;

  localparam int LETTER_W = 5;
  localparam int CODE_W   = 7;
  localparam int KEY_W    = 15;
  localparam int ACC_W    = 12;   // 3 * 31 * 25 fits
  localparam int QUOT_W   = 7;    // acc / 26 fits
  localparam int RECIP_W  = 12;
  localparam int PROD_W   = ACC_W + RECIP_W;

  localparam int ALPHA       = 26;
  localparam int CODE_A      = 65;
  localparam int CODE_Z      = 90;
  localparam int PAD_INDEX   = 25;
  // floor(x * 2521 / 2^16) == floor(x / 26) for every x up to 3 * 31 * 25
  localparam int RECIP       = 2521;
  localparam int RECIP_SHIFT = 16;

  localparam int KEY_ROW0_RST = 7266;
  localparam int KEY_ROW1_RST = 9445;
  localparam int KEY_ROW2_RST = 11329;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW2 = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAD,
    ST_READ,
    ST_MAC,
    ST_QUOT,
    ST_REM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic mac;
    logic quot;
  } mac_ctl_t;

endpackage

@@ design/hc3_mod26.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc3_mod26
// Shared multiply-accumulate unit with a reciprocal based mod-26 reduction.
// ----------------------------------------------------------------------------
module hc3_mod26 (
  input  logic                          clk,
  input  hc3_pkg::mac_ctl_t             ctl,
  input  logic [hc3_pkg::LETTER_W-1:0]  key_ent,
  input  logic [hc3_pkg::LETTER_W-1:0]  letter,
  output logic [hc3_pkg::LETTER_W-1:0]  rem
);
  import hc3_pkg::*;

  logic [ACC_W-1:0]          acc;
  logic [QUOT_W-1:0]         quot;
  logic [2*LETTER_W-1:0]     prod;
  logic [PROD_W-1:0]         qprod;
  logic [ACC_W-1:0]          rem_full;

  assign prod  = key_ent * letter;
  assign qprod = PROD_W'(acc) * PROD_W'(RECIP);
  // q * 26 is a constant multiply, shifts and adds
  assign rem_full = acc - ACC_W'(quot) * ACC_W'(ALPHA);
  assign rem = rem_full[LETTER_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.mac) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctl.quot) begin
      quot <= qprod[RECIP_SHIFT +: QUOT_W];
    end
  end

endmodule

@@ design/hill_cipher_3x3_mod26_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_3x3_mod26_top
// Hill cipher over A..Z with a 3x3 key: stores a message, pads it with Z and
// emits the enciphered rows one letter per output beat.
// ----------------------------------------------------------------------------
// Letters are taken one per cycle into a letter store of (MAX_LETTERS / 3) * 3
// entries while the block is loading. The beat marked last_letter ends the
// message: the block then pads it with Z letters (up to two) to a multiple of
// three, during which input is stalled, and then works out every result letter
// in turn by three store reads each followed by a multiply-accumulate in the
// single shared unit, then the reciprocal quotient, then the remainder, and
// then holds the result on the output until taken. Input resumes once the
// final result letter has been taken. Letters past capacity are dropped and
// reported on overflowed with every result letter of that message.
module hill_cipher_3x3_mod26_top #(
  parameter int MAX_LETTERS = hc3_pkg::DEF_MAX_LETTERS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hc3_pkg::CODE_W-1:0]    letter_code,
  input  logic                          last_letter,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hc3_pkg::CODE_W-1:0]    out_code,
  output logic                          out_last,
  output logic                          overflowed,
  input  logic                          cfg_write_en,
  input  logic [hc3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hc3_pkg::KEY_W-1:0]     cfg_data
);
  import hc3_pkg::*;

  localparam int CAPACITY = (MAX_LETTERS / 3) * 3;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);

  state_t state, state_next;

  logic [KEY_W-1:0]    key_row0, key_row1, key_row2;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    len;
  logic [1:0]          mod3;
  logic                drop;
  logic [1:0]          row;
  logic [1:0]          tap;
  logic [CNT_W-1:0]    col;
  logic [CNT_W-1:0]    addr;

  logic [LETTER_W-1:0] mem [CAPACITY];
  logic [LETTER_W-1:0] rdata;
  logic                mem_we;
  logic [LETTER_W-1:0] mem_wdata;

  logic                in_accept;
  logic                out_accept;
  logic                is_letter;
  logic                has_room;
  logic                last_col;
  logic                last_res;
  logic [CODE_W-1:0]   letter_off;
  logic [KEY_W-1:0]    key_row;
  logic [LETTER_W-1:0] key_ent;
  logic [LETTER_W-1:0] rem;
  mac_ctl_t            ctl;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign is_letter  = (letter_code >= CODE_W'(CODE_A)) && (letter_code <= CODE_W'(CODE_Z));
  assign has_room   = count < CNT_W'(CAPACITY);
  assign letter_off = letter_code - CODE_W'(CODE_A);
  assign last_col   = col == (len - CNT_W'(1));
  assign last_res   = last_col && (row == 2'd2);

  // key entry for the current output row and tap
  always_comb begin
    case (row)
      2'd0:    key_row = key_row0;
      2'd1:    key_row = key_row1;
      default: key_row = key_row2;
    endcase
    case (tap)
      2'd0:    key_ent = key_row[0 +: LETTER_W];
      2'd1:    key_ent = key_row[LETTER_W +: LETTER_W];
      default: key_ent = key_row[2*LETTER_W +: LETTER_W];
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_accept && last_letter) state_next = ST_PAD;
      end
      ST_PAD: begin
        if (mod3 == 2'd0) begin
          state_next = (len == '0) ? ST_LOAD : ST_READ;
        end
      end
      ST_READ: state_next = ST_MAC;
      ST_MAC:  state_next = (tap == 2'd2) ? ST_QUOT : ST_READ;
      ST_QUOT: state_next = ST_REM;
      ST_REM:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_accept) state_next = last_res ? ST_LOAD : ST_READ;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_wdata = LETTER_W'(PAD_INDEX);
    ctl       = '0;
    unique case (state)
      ST_LOAD: begin
        in_stall  = 1'b0;
        mem_we    = in_accept && is_letter && has_room;
        mem_wdata = letter_off[LETTER_W-1:0];
      end
      ST_PAD: begin
        mem_we    = mod3 != 2'd0;
        ctl.clear = 1'b1;
      end
      ST_MAC:  ctl.mac   = 1'b1;
      ST_QUOT: ctl.quot  = 1'b1;
      ST_OUT:  ctl.clear = 1'b1;
      default: ;
    endcase
  end

  // letter store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[ADDR_W-1:0]] <= mem_wdata;
    end
    rdata <= mem[addr[ADDR_W-1:0]];
  end

  hc3_mod26 u_mod26 (
    .clk     (clk),
    .ctl     (ctl),
    .key_ent (key_ent),
    .letter  (rdata),
    .rem     (rem)
  );

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_row0 <= KEY_W'(KEY_ROW0_RST);
      key_row1 <= KEY_W'(KEY_ROW1_RST);
      key_row2 <= KEY_W'(KEY_ROW2_RST);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_KEY_ROW0: key_row0 <= cfg_data;
        REG_KEY_ROW1: key_row1 <= cfg_data;
        REG_KEY_ROW2: key_row2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      len       <= '0;
      mod3      <= 2'd0;
      drop      <= 1'b0;
      row       <= 2'd0;
      tap       <= 2'd0;
      col       <= '0;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (mem_we) begin
        count <= count + CNT_W'(1);
        if (mod3 == 2'd2) begin
          mod3 <= 2'd0;
          len  <= len + CNT_W'(1);
        end else begin
          mod3 <= mod3 + 2'd1;
        end
      end

      unique case (state)
        ST_LOAD: begin
          if (in_accept && is_letter && !has_room) drop <= 1'b1;
        end
        ST_PAD: begin
          if (mod3 == 2'd0) begin
            if (len == '0) begin
              count <= '0;
              drop  <= 1'b0;
            end
            row  <= 2'd0;
            col  <= '0;
            tap  <= 2'd0;
            addr <= '0;
          end
        end
        ST_MAC: begin
          // walk down the column: j, j + len, j + 2 * len
          if (tap != 2'd2) begin
            tap  <= tap + 2'd1;
            addr <= addr + len;
          end
        end
        ST_REM: out_valid <= 1'b1;
        ST_OUT: begin
          if (out_accept) begin
            out_valid <= 1'b0;
            tap       <= 2'd0;
            if (last_res) begin
              count <= '0;
              len   <= '0;
              drop  <= 1'b0;
            end else if (last_col) begin
              row  <= row + 2'd1;
              col  <= '0;
              addr <= '0;
            end else begin
              col  <= col + CNT_W'(1);
              addr <= col + CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (state == ST_REM) begin
      out_code   <= CODE_W'(CODE_A) + CODE_W'(rem);
      out_last   <= last_res;
      overflowed <= drop;
    end
  end

endmodule

@@ tb/hill_letter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_letter_checker
// Watches the letter, result and key-write ports of the hill cipher block,
// predicts every enciphered letter from its own copy of the key and message
// store, and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module hill_letter_checker #(
  parameter int MAX_LETTERS = hc3_pkg::DEF_MAX_LETTERS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [hc3_pkg::CODE_W-1:0]    letter_code,
  input  logic                          last_letter,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [hc3_pkg::CODE_W-1:0]    out_code,
  input  logic                          out_last,
  input  logic                          overflowed,
  input  logic                          cfg_write_en,
  input  logic [hc3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hc3_pkg::KEY_W-1:0]     cfg_data,
  output int                            letter_mismatches,
  output int                            letters_due
);
  import hc3_pkg::*;

  localparam int CAPACITY = (MAX_LETTERS / 3) * 3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              tail;
    logic              ovf;
  } cipher_letter_t;

  logic [KEY_W-1:0]    key_row [3];
  logic [LETTER_W-1:0] msg_store [CAPACITY];
  int                  msg_len;
  bit                  msg_dropped;
  cipher_letter_t      cipher_due [$];

  function automatic int key_entry(int row, int col);
    return int'(key_row[row][LETTER_W*col +: LETTER_W]);
  endfunction

  // store one letter; on the marked beat pad with z and queue the whole cipher text
  task automatic encipher_beat(input logic [CODE_W-1:0] code, input logic tail);
    int rows;
    int sum;
    cipher_letter_t beat;
    if (code >= CODE_A && code <= CODE_Z) begin
      if (msg_len < CAPACITY) begin
        msg_store[msg_len] = LETTER_W'(code - CODE_A);
        msg_len++;
      end else begin
        msg_dropped = 1'b1;
      end
    end
    if (tail) begin
      while (msg_len % 3 != 0 && msg_len < CAPACITY) begin
        msg_store[msg_len] = LETTER_W'(PAD_INDEX);
        msg_len++;
      end
      rows = msg_len / 3;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < rows; j++) begin
          sum = 0;
          for (int z = 0; z < 3; z++) begin
            sum += key_entry(i, z) * int'(msg_store[j + rows * z]);
          end
          beat.code = CODE_W'(CODE_A + sum % ALPHA);
          beat.tail = (i == 2 && j == rows - 1);
          beat.ovf  = msg_dropped;
          cipher_due.push_back(beat);
        end
      end
      msg_len     = 0;
      msg_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    cipher_letter_t want;
    if (rst) begin
      key_row[0]        = KEY_W'(KEY_ROW0_RST);
      key_row[1]        = KEY_W'(KEY_ROW1_RST);
      key_row[2]        = KEY_W'(KEY_ROW2_RST);
      msg_len           = 0;
      msg_dropped       = 1'b0;
      letter_mismatches = 0;
      cipher_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_due.size() == 0) begin
          $error("out_code: expected no beat, got %0d", out_code);
          letter_mismatches++;
        end else begin
          want = cipher_due.pop_front();
          if (out_code !== want.code) begin
            $error("out_code: expected %0d, got %0d", want.code, out_code);
            letter_mismatches++;
          end
          if (out_last !== want.tail) begin
            $error("out_last: expected %0d, got %0d", want.tail, out_last);
            letter_mismatches++;
          end
          if (overflowed !== want.ovf) begin
            $error("overflowed: expected %0d, got %0d", want.ovf, overflowed);
            letter_mismatches++;
          end
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          REG_KEY_ROW0: key_row[0] = cfg_data;
          REG_KEY_ROW1: key_row[1] = cfg_data;
          REG_KEY_ROW2: key_row[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        encipher_beat(letter_code, last_letter);
      end
    end
    letters_due <= cipher_due.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives messages and key writes into the 3x3 mod-26 hill cipher block with
// random gaps and output stalls; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import hc3_pkg::*;

  localparam int STORE_LETTERS = (DEF_MAX_LETTERS / 3) * 3;
  localparam int RANDOM_LETTERS = 400;
  localparam int PHASES = 6;
  localparam int SETTLE_CYCLES = 40;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic [CODE_W-1:0]    letter_code  = CODE_W'(CODE_A);
  logic                 last_letter  = 1'b0;
  logic                 out_stall    = 1'b0;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_KEY_ROW0;
  logic [KEY_W-1:0]     cfg_data     = '0;

  logic              in_stall;
  logic              out_valid;
  logic [CODE_W-1:0] out_code;
  logic              out_last;
  logic              overflowed;

  int letter_mismatches;
  int letters_due;
  int letters_sent = 0;
  int msg_no = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  always #10 clk = ~clk;

  hill_cipher_3x3_mod26_top #(
    .MAX_LETTERS(DEF_MAX_LETTERS)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .letter_code(letter_code), .last_letter(last_letter),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code(out_code), .out_last(out_last), .overflowed(overflowed),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hill_letter_checker #(
    .MAX_LETTERS(DEF_MAX_LETTERS)
  ) watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .letter_code(letter_code), .last_letter(last_letter),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code(out_code), .out_last(out_last), .overflowed(overflowed),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .letter_mismatches(letter_mismatches), .letters_due(letters_due)
  );

  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // any 7-bit code outside A..Z
  function automatic logic [CODE_W-1:0] junk_code();
    logic [CODE_W-1:0] c;
    c = CODE_W'($urandom_range(0, 127));
    if (c >= CODE_A && c <= CODE_Z) begin
      c = c ^ 7'h40;
    end
    return c;
  endfunction

  function automatic logic [KEY_W-1:0] pack_row(int a, int b, int c);
    return {LETTER_W'(c), LETTER_W'(b), LETTER_W'(a)};
  endfunction

  function automatic logic [KEY_W-1:0] rand_row();
    return pack_row($urandom_range(0, 25), $urandom_range(0, 25), $urandom_range(0, 25));
  endfunction

  // output side: hold stall for a drawn number of cycles, then take one beat
  always begin : drain
    int hold;
    hold = draw_wait(calm_out);
    if (hold != 0) begin
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (out_valid !== 1'b1);
  end

  task automatic send_beat(input logic [CODE_W-1:0] code, input logic tail);
    int gap;
    gap = draw_wait(calm_in);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    letter_code <= code;
    last_letter <= tail;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_letter(input int idx, input logic tail);
    send_beat(CODE_W'(CODE_A + idx), tail);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (letters_due != 0);
  endtask

  task automatic load_key(input logic [KEY_W-1:0] r0, r1, r2);
    wait_drained();
    // an empty message gives no beat but may still keep the block busy
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_KEY_ROW0;
    cfg_data     <= r0;
    @(posedge clk);
    cfg_index    <= REG_KEY_ROW1;
    cfg_data     <= r1;
    @(posedge clk);
    cfg_index    <= REG_KEY_ROW2;
    cfg_data     <= r2;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic send_message(input int n, input int junk_pct, input bit junk_end);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < junk_pct) begin
        send_beat(junk_code(), 1'b0);
      end
      send_letter($urandom_range(0, 25), (k == n - 1) && !junk_end);
      letters_sent++;
    end
    if (junk_end) begin
      send_beat(junk_code(), 1'b1);
    end
  endtask

  task automatic send_random_message();
    int pick;
    int n;
    int junk_pct;
    bit junk_end;
    pick = $urandom_range(0, 19);
    // make sure an overflowing message and one that fills the store when padded come early
    if (msg_no == 0) begin
      pick = 17;
    end else if (msg_no == 1) begin
      pick = 15;
    end
    if (pick <= 10) begin
      n = $urandom_range(1, 9);
    end else if (pick <= 14) begin
      n = $urandom_range(10, 30);
    end else if (pick <= 16) begin
      n = $urandom_range(STORE_LETTERS - 2, STORE_LETTERS);
    end else if (pick <= 18) begin
      n = $urandom_range(STORE_LETTERS + 1, STORE_LETTERS + 8);
    end else begin
      n = 0;
    end
    junk_end = (n == 0) || ($urandom_range(0, 5) == 0);
    junk_pct = ($urandom_range(0, 3) == 0) ? 10 : 0;
    calm_in  = ($urandom_range(0, 4) == 0);
    calm_out = ($urandom_range(0, 4) == 0);
    send_message(n, junk_pct, junk_end);
    msg_no++;
    if ($urandom_range(0, 5) == 0) begin
      wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed messages under the reset key
    send_letter(0, 1'b1);
    send_letter(25, 1'b0);
    send_letter(25, 1'b0);
    send_letter(25, 1'b1);
    send_letter(0, 1'b0);
    send_beat(CODE_W'(CODE_A - 1), 1'b0);
    send_letter(1, 1'b0);
    send_beat(CODE_W'(CODE_Z + 1), 1'b0);
    send_letter(2, 1'b0);
    send_letter(3, 1'b1);
    send_letter(7, 1'b0);
    send_letter(8, 1'b0);
    send_beat(7'h00, 1'b1);
    send_beat(7'h7f, 1'b1);
    send_beat(7'h7f, 1'b0);
    send_letter(25, 1'b0);
    send_letter(0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_key('0, '0, '0);
        1: load_key('1, '1, '1);
        2: load_key(rand_row(), rand_row(), rand_row());
        3: load_key(KEY_W'($urandom_range(0, 32767)), KEY_W'($urandom_range(0, 32767)),
                    KEY_W'($urandom_range(0, 32767)));
        4: load_key(pack_row(6, 24, 1), pack_row(13, 16, 10), pack_row(20, 17, 15));
        default: load_key(pack_row(8, 5, 10), pack_row(21, 8, 21), pack_row(21, 12, 8));
      endcase
      while (letters_sent < (p + 1) * RANDOM_LETTERS / PHASES) begin
        send_random_message();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (letter_mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
design/hc3_pkg.sv
design/hc3_mod26.sv
design/hill_cipher_3x3_mod26_top.sv
tb/hill_letter_checker.sv
tb/testbench.sv
